@@ design/tlrl_pkg.sv @@
// Shared types and codes for the three-level ready list.
`timescale 1ns / 1ps
`default_nettype none

package tlrl_pkg;

   localparam int DEF_LIST_DEPTH = 16;
   localparam int DEF_PID_BITS   = 8;

   // operation codes
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_DEL   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // priority level that names no list
   localparam logic [1:0] LVL_INVALID = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_SUCCESS   = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_BAD_PRIO  = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

@@ design/tlrl_store.sv @@
// Entry memory for all three lists: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tlrl_store
   import tlrl_pkg::*;
#(
   parameter int PID_BITS = DEF_PID_BITS,
   parameter int ADDR_W   = 6,
   parameter int WORDS    = 48
) (
   input  wire logic                clock,
   input  wire mem_ctl_type         ctl,
   input  wire logic [ADDR_W-1:0]   waddr,
   input  wire logic [PID_BITS-1:0] wdata,
   input  wire logic [ADDR_W-1:0]   raddr,
   output logic      [PID_BITS-1:0] rdata
);

   logic [PID_BITS-1:0] mem [WORDS];
   logic [PID_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/tlrl_seq.sv @@
// Sequencer: decode, one-entry-per-cycle scan and compare, shift-down on delete, result register.
`timescale 1ns / 1ps
`default_nettype none

module tlrl_seq
   import tlrl_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int PID_BITS   = DEF_PID_BITS,
   parameter int IDX_W      = $clog2(LIST_DEPTH),
   parameter int CNT_W      = $clog2(LIST_DEPTH + 1),
   parameter int ADDR_W     = IDX_W + 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_kind,
   input  wire logic [PID_BITS-1:0] req_pid,
   input  wire logic [1:0]          req_priority_req,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_ok,
   output logic      [1:0]          rsp_status,
   output mem_ctl_type              mem_ctl,
   output logic      [ADDR_W-1:0]   mem_waddr,
   output logic      [PID_BITS-1:0] mem_wdata,
   output logic      [ADDR_W-1:0]   mem_raddr,
   input  wire logic [PID_BITS-1:0] mem_rdata
);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

   seq_state_type       state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          lvl_ff, lvl_in;
   logic [PID_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ok_ff, pend_ok_in;
   logic [1:0]          pend_stat_ff, pend_stat_in;
   logic [CNT_W-1:0]    counts_ff [3];
   logic [CNT_W-1:0]    counts_in [3];
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                lvl_ok;
   logic [CNT_W-1:0]    sel_cnt;
   logic                is_search;
   logic                start_scan;
   logic                match;
   logic                last;
   logic                out_free;
   logic [IDX_W-1:0]    idx_p1;
   logic [IDX_W-1:0]    idx_p2;

   assign lvl_ok     = (req_priority_req != LVL_INVALID);
   assign sel_cnt    = lvl_ok ? counts_ff[req_priority_req] : '0;
   assign is_search  = (req_kind == KIND_DEL) || (req_kind == KIND_QUERY);
   assign start_scan = lvl_ok && is_search && (sel_cnt != '0);
   assign match      = (mem_rdata == key_ff);
   assign last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign idx_p1     = idx_ff + IDX_W'(1);
   assign idx_p2     = idx_ff + IDX_W'(2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = start_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = (kind_ff == KIND_DEL) ? ST_SHIFT : ST_FINISH;
            end else if (last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in       = kind_ff;
      lvl_in        = lvl_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_ok_in    = pend_ok_ff;
      pend_stat_in  = pend_stat_ff;
      counts_in     = counts_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      mem_waddr     = {lvl_ff, idx_ff};
      mem_wdata     = mem_rdata;
      mem_raddr     = {lvl_ff, idx_p1};
      case (state_ff)
         ST_IDLE: begin
            mem_raddr = {req_priority_req, {IDX_W{1'b0}}};
            if (req_valid) begin
               kind_in      = req_kind;
               lvl_in       = req_priority_req;
               key_in       = req_pid;
               idx_in       = '0;
               cnt_in       = sel_cnt;
               pend_ok_in   = 1'b0;
               pend_stat_in = STAT_NOT_FOUND;
               if (!lvl_ok) begin
                  pend_stat_in = STAT_BAD_PRIO;
               end else if (req_kind == KIND_ADD) begin
                  if (sel_cnt == FULL_CNT) begin
                     pend_stat_in = STAT_FULL;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     mem_waddr     = {req_priority_req, sel_cnt[IDX_W-1:0]};
                     mem_wdata     = req_pid;
                     counts_in[req_priority_req] = sel_cnt + CNT_W'(1);
                     pend_ok_in    = 1'b1;
                     pend_stat_in  = STAT_SUCCESS;
                  end
               end
               mem_ctl.rd_en = start_scan;
            end
         end
         ST_SCAN: begin
            // read of the next entry is issued while this one is compared
            mem_ctl.rd_en = 1'b1;
            if (match) begin
               if (kind_ff != KIND_DEL) begin
                  pend_ok_in   = 1'b1;
                  pend_stat_in = STAT_SUCCESS;
               end
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_SHIFT: begin
            if (last) begin
               counts_in[lvl_ff] = cnt_ff - CNT_W'(1);
               pend_ok_in        = 1'b1;
               pend_stat_in      = STAT_SUCCESS;
            end else begin
               // rdata holds entry idx+1; move it down one slot
               mem_ctl.wr_en = 1'b1;
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = {lvl_ff, idx_p2};
               idx_in        = idx_p1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = pend_ok_ff;
               rsp_status_in = pend_stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         counts_ff    <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      lvl_ff        <= lvl_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_ok_ff    <= pend_ok_in;
      pend_stat_ff  <= pend_stat_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

@@ design/three_level_ready_list.sv @@
// Top level of the three-level ready list: sequencer plus shared entry memory.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_kind, req_pid, req_priority_req
//   rsp     | out       | rsp_valid / rsp_ready | rsp_ok, rsp_status
//
// Add, bad priority, unused kind and a search of an empty list go straight to finish.
// Query and delete scan to a match or the list end; a found delete shifts later entries down.
// The single memory read port walks one entry per cycle for scan and shift.
// Reset clears the three list counts; entry memory needs no clearing.
// A waiting result blocks only the finish step; the next item is still taken.
`timescale 1ns / 1ps
`default_nettype none

module three_level_ready_list
   import tlrl_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int PID_BITS   = DEF_PID_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_kind,
   input  wire logic [PID_BITS-1:0] req_pid,
   input  wire logic [1:0]          req_priority_req,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_ok,
   output logic      [1:0]          rsp_status
);

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = IDX_W + 2;
   localparam int WORDS  = 3 << IDX_W;

   mem_ctl_type         mem_ctl;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [PID_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [PID_BITS-1:0] mem_rdata;

   tlrl_seq #(
      .LIST_DEPTH (LIST_DEPTH),
      .PID_BITS   (PID_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .ADDR_W     (ADDR_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pid          (req_pid),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_status       (rsp_status),
      .mem_ctl          (mem_ctl),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

   tlrl_store #(
      .PID_BITS (PID_BITS),
      .ADDR_W   (ADDR_W),
      .WORDS    (WORDS)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

@@ design/tlrl_check.sv @@
// Port-level assertions for the three-level ready list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tlrl_check
   import tlrl_pkg::*;
#(
   parameter int PID_BITS = DEF_PID_BITS
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [1:0]          req_kind,
   input wire logic [PID_BITS-1:0] req_pid,
   input wire logic [1:0]          req_priority_req,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_ok,
   input wire logic [1:0]          rsp_status
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_status))
      else $error("stalled result changed");

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kind) && $stable(req_pid)
         && $stable(req_priority_req))
      else $error("waiting request changed");

   // ok and success status agree
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ok == (rsp_status == STAT_SUCCESS)))
      else $error("ok flag disagrees with status");

   // ready goes low once an item is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after accept");

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind three_level_ready_list tlrl_check #(.PID_BITS(PID_BITS)) u_check (.*);

`default_nettype wire
